// ===== rtl/hidt_pkg.sv =====
package hidt_pkg;

	localparam int unsigned ByteW   = 8;
	localparam int unsigned TypeW   = 2;
	localparam int unsigned TagW    = 4;
	localparam int unsigned LenW    = 3;
	localparam int unsigned ValueW  = 32;
	localparam int unsigned KindW   = 5;
	localparam int unsigned InDataW = 8;
	localparam int unsigned OutDataW = 48;
	localparam int unsigned OutUserW = 2;

	localparam logic [ByteW-1:0] EndCollPrefix = 8'hC0;

	// prefix type field codes
	localparam logic [TypeW-1:0] TypeMain     = 2'd0;
	localparam logic [TypeW-1:0] TypeGlobal   = 2'd1;
	localparam logic [TypeW-1:0] TypeLocal    = 2'd2;
	localparam logic [TypeW-1:0] TypeReserved = 2'd3;

	// prefix size field codes
	localparam logic [1:0] SizeNone  = 2'd0;
	localparam logic [1:0] SizeFour  = 2'd3;

	localparam logic [KindW-1:0] KindMainBase   = 5'd16;
	localparam logic [KindW-1:0] KindGlobalHigh = 5'd17;
	localparam logic [KindW-1:0] KindEndColl    = 5'd24;
	localparam logic [KindW-1:0] KindReserved   = 5'd25;
	localparam logic [KindW-1:0] KindUnnamed    = 5'd26;

	typedef struct packed {
		logic [TypeW-1:0]  item_type;
		logic [TagW-1:0]   item_tag;
		logic [LenW-1:0]   data_length;
		logic [ValueW-1:0] item_value;
		logic [KindW-1:0]  item_kind;
		logic              end_collection;
		logic              truncated;
	} hidt_res_t;

endpackage

// ===== rtl/hidt_kind_dec.sv =====
module hidt_kind_dec import hidt_pkg::*; (
	input  logic [ByteW-1:0] prefix,
	output logic [KindW-1:0] kind
);

	logic [TypeW-1:0] typ;
	logic [TagW-1:0]  tag;
	logic [KindW-1:0] tag_x2;
	logic [KindW-1:0] hi_x2;

	assign typ    = prefix[3:2];
	assign tag    = prefix[7:4];
	assign tag_x2 = {tag, 1'b0};
	// tags 8..12: (tag - 8) * 2
	assign hi_x2  = {1'b0, tag[2:0], 1'b0};

	always_comb begin
		kind = KindUnnamed;
		if (tag >= 4'd13) begin
			kind = KindReserved;
		end else if (tag <= 4'd7) begin
			unique case (typ)
				TypeGlobal: kind = tag_x2;
				TypeLocal:  kind = tag_x2 | 5'd1;
				default:    kind = KindUnnamed;
			endcase
		end else begin
			unique case (typ)
				TypeLocal:  kind = KindReserved;
				TypeMain:   kind = KindMainBase + hi_x2;
				TypeGlobal: kind = (tag <= 4'd11) ? KindGlobalHigh + hi_x2 : KindUnnamed;
				default:    kind = KindUnnamed;
			endcase
		end
	end

endmodule

// ===== rtl/hidt_step.sv =====
module hidt_step import hidt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             beat,
	input  logic [ByteW-1:0] desc_byte,
	input  logic             first_byte,
	input  logic             last_byte,
	output logic             res_valid,
	output hidt_res_t        res
);

	logic [ByteW-1:0]  prefix_q, prefix_d;
	logic [LenW-1:0]   left_q, left_d;
	logic [LenW-1:0]   taken_q, taken_d;
	logic [ValueW-1:0] acc_q, acc_d;
	logic              in_item_q, in_item_d;
	logic              emit, trunc, collecting;
	logic [LenW-1:0]   size;
	logic [KindW-1:0]  kind;

	assign collecting = in_item_q & ~first_byte;
	assign size = (desc_byte[1:0] == SizeFour) ? 3'd4 : {1'b0, desc_byte[1:0]};

	always_comb begin
		prefix_d  = prefix_q;
		left_d    = left_q;
		taken_d   = taken_q;
		acc_d     = acc_q;
		in_item_d = in_item_q;
		emit      = 1'b0;
		trunc     = 1'b0;
		if (!collecting) begin
			prefix_d  = desc_byte;
			left_d    = size;
			taken_d   = '0;
			acc_d     = '0;
			in_item_d = 1'b1;
			if (desc_byte[1:0] == SizeNone) begin
				emit = 1'b1;
			end else if (last_byte) begin
				emit  = 1'b1;
				trunc = 1'b1;
			end
		end else begin
			acc_d   = acc_q | (ValueW'(desc_byte) << {taken_q[1:0], 3'b000});
			taken_d = taken_q + 3'd1;
			if (left_q != '0)
				left_d = left_q - 3'd1;
			if (left_d == '0) begin
				emit = 1'b1;
			end else if (last_byte) begin
				emit  = 1'b1;
				trunc = 1'b1;
			end
		end
		// emitting closes the item
		if (emit) begin
			in_item_d = 1'b0;
			left_d    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q  <= '0;
			left_q    <= '0;
			taken_q   <= '0;
			acc_q     <= '0;
			in_item_q <= 1'b0;
		end else if (beat) begin
			prefix_q  <= prefix_d;
			left_q    <= left_d;
			taken_q   <= taken_d;
			acc_q     <= acc_d;
			in_item_q <= in_item_d;
		end
	end

	hidt_kind_dec u_kind (
		.prefix (prefix_d),
		.kind   (kind)
	);

	assign res_valid = beat & emit;
	always_comb begin
		res.item_type      = prefix_d[3:2];
		res.item_tag       = prefix_d[7:4];
		res.data_length    = taken_d;
		res.item_value     = acc_d;
		res.item_kind      = kind;
		res.end_collection = (prefix_d == EndCollPrefix);
		res.truncated      = trunc;
	end

endmodule

// ===== rtl/hid_descriptor_item_tokenizer.sv =====
// HID report descriptor tokenizer: feed the descriptor one byte per beat
// (tuser marks the first byte of a descriptor, tlast the final one) and one
// beat comes out for every complete short item, or for a partial item cut off
// by tlast, flagged truncated. Size code three carries four data bytes. A byte
// goes in each cycle while the output is not stalled; a byte is registered,
// decoded combinationally against the item state and its result registered.
// Back-pressure on the output stalls the input register only once the result
// register is full.
module hid_descriptor_item_tokenizer import hidt_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [InDataW-1:0]  s_tdata,   // [7:0] desc_byte
	input  logic                s_tuser,   // first_byte
	input  logic                s_tlast,   // last_byte
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OutDataW-1:0] m_tdata,   // [1:0] item_type, [5:2] item_tag,
	                                       // [8:6] data_length, [40:9] item_value,
	                                       // [45:41] item_kind, [47:46] zero
	output logic [OutUserW-1:0] m_tuser    // [0] end_collection, [1] truncated
);

	logic             valid_s1;
	logic [ByteW-1:0] byte_s1;
	logic             first_s1;
	logic             last_s1;
	logic             valid_s2;
	hidt_res_t        res_s2;
	logic             advance;
	logic             res_valid;
	hidt_res_t        res;

	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1  <= s_tdata[ByteW-1:0];
			first_s1 <= s_tuser;
			last_s1  <= s_tlast;
		end
	end

	hidt_step u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.beat       (valid_s1 && advance),
		.desc_byte  (byte_s1),
		.first_byte (first_s1),
		.last_byte  (last_s1),
		.res_valid  (res_valid),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid)
			res_s2 <= res;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {2'b00, res_s2.item_kind, res_s2.item_value, res_s2.data_length,
		res_s2.item_tag, res_s2.item_type};
	assign m_tuser  = {res_s2.truncated, res_s2.end_collection};

	a_len_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (res_s2.data_length <= 3'd4))
		else $error("data length beyond four");

	a_value_width: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_s2.data_length == 3'd1) |-> (res_s2.item_value[31:8] == '0))
		else $error("value wider than received bytes");

	a_end_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_s2.end_collection) |-> (res_s2.item_kind == KindEndColl))
		else $error("end collection with wrong kind");

	a_trunc_len: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_s2.truncated) |-> (res_s2.data_length != 3'd4))
		else $error("truncated item with full data");

	a_empty_size: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !res_s2.truncated && res_s2.data_length == 3'd0)
			|-> (res_s2.item_value == '0))
		else $error("empty item carries a value");

endmodule

// ===== sim/hid_descriptor_item_tokenizer_tb.sv =====
module hid_descriptor_item_tokenizer_tb;
	import hidt_pkg::*;

	localparam int unsigned IdleLimit   = 4000;
	localparam int unsigned DrainCycles = 20;
	localparam int unsigned HoldCycles  = 400;
	localparam int unsigned MaxReports  = 10;

	localparam logic [TagW-1:0] TagLastShort     = 4'd7;
	localparam logic [TagW-1:0] TagFirstLong     = 4'd8;
	localparam logic [TagW-1:0] TagLastGlobal    = 4'd11;
	localparam logic [TagW-1:0] TagFirstReserved = 4'd13;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [InDataW-1:0]  s_tdata  = '0;
	logic                s_tuser  = 1'b0;
	logic                s_tlast  = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OutDataW-1:0] m_tdata;
	logic [OutUserW-1:0] m_tuser;

	// tokenizer state as the testbench tracks it
	logic [ByteW-1:0]  cur_prefix = '0;
	logic [LenW-1:0]   left_cnt   = '0;
	logic [LenW-1:0]   taken_cnt  = '0;
	logic [ValueW-1:0] acc_value  = '0;
	bit                mid_item   = 1'b0;

	hidt_res_t expected_items[$];

	bit          src_gaps     = 1'b1;
	bit          snk_gaps     = 1'b1;
	int unsigned hold_request = 0;
	int unsigned bytes_sent   = 0;
	int unsigned items_seen   = 0;
	int unsigned trunc_seen   = 0;
	int unsigned endc_seen    = 0;
	int unsigned n_errors     = 0;
	int unsigned idle_cycles  = 0;

	hid_descriptor_item_tokenizer u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [LenW-1:0] data_bytes(input logic [ByteW-1:0] p);
		return (p[1:0] == SizeFour) ? LenW'(4) : LenW'(p[1:0]);
	endfunction

	function automatic logic [KindW-1:0] kind_code(input logic [ByteW-1:0] p);
		logic [TypeW-1:0] ty;
		logic [TagW-1:0]  tg;
		ty = p[3:2];
		tg = p[7:4];
		if (tg >= TagFirstReserved)
			return KindReserved;
		if (tg <= TagLastShort) begin
			if (ty == TypeGlobal)
				return {tg, 1'b0};
			if (ty == TypeLocal)
				return {tg, 1'b1};
			return KindUnnamed;
		end
		if (ty == TypeLocal)
			return KindReserved;
		if (ty == TypeMain)
			return KindMainBase + {tg - TagFirstLong, 1'b0};
		if (ty == TypeGlobal && tg <= TagLastGlobal)
			return KindGlobalHigh + {tg - TagFirstLong, 1'b0};
		return KindUnnamed;
	endfunction

	function automatic string item_text(input hidt_res_t r);
		return $sformatf("type %0d tag %0d len %0d value %h kind %0d endc %0b trunc %0b",
			r.item_type, r.item_tag, r.data_length, r.item_value, r.item_kind,
			r.end_collection, r.truncated);
	endfunction

	// advance the tracked state by one accepted byte and queue any finished item
	task automatic track_byte(input logic [ByteW-1:0] b, input bit fst, input bit lst);
		hidt_res_t r;
		bit        done_item;
		bit        cut;
		done_item = 1'b0;
		cut       = 1'b0;
		if (fst)
			mid_item = 1'b0;
		if (!mid_item) begin
			cur_prefix = b;
			left_cnt   = data_bytes(b);
			taken_cnt  = '0;
			acc_value  = '0;
			if (left_cnt == 0) begin
				done_item = 1'b1;
			end else begin
				mid_item = 1'b1;
				if (lst) begin
					done_item = 1'b1;
					cut       = 1'b1;
				end
			end
		end else begin
			acc_value = acc_value | (ValueW'(b) << (8 * taken_cnt[1:0]));
			taken_cnt = taken_cnt + 1'b1;
			if (left_cnt != 0)
				left_cnt = left_cnt - 1'b1;
			if (left_cnt == 0) begin
				done_item = 1'b1;
			end else if (lst) begin
				done_item = 1'b1;
				cut       = 1'b1;
			end
		end
		if (done_item) begin
			r.item_type      = cur_prefix[3:2];
			r.item_tag       = cur_prefix[7:4];
			r.data_length    = taken_cnt;
			r.item_value     = acc_value;
			r.item_kind      = kind_code(cur_prefix);
			r.end_collection = (cur_prefix == EndCollPrefix);
			r.truncated      = cut;
			mid_item = 1'b0;
			left_cnt = '0;
			expected_items = {expected_items, r};
		end
	endtask

	task automatic drive_byte(input logic [ByteW-1:0] b, input bit fst, input bit lst);
		@(negedge clk);
		if (src_gaps && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= fst;
		s_tlast  <= lst;
		do @(posedge clk); while (!s_tready);
		track_byte(b, fst, lst);
		bytes_sent++;
	endtask

	task automatic stop_driving();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	// one descriptor of random short items; a ragged one breaks off part-way through an
	// item, either flagged last (truncated result) or abandoned for the next first byte
	task automatic send_descriptor(input int unsigned n_items, input bit ragged);
		logic [ByteW-1:0] pfx;
		int unsigned      stop_item;
		int unsigned      k;
		bit               abandon;
		bit               flag_end;
		stop_item = ragged ? $urandom_range(0, n_items - 1) : n_items;
		abandon   = ($urandom_range(0, 2) == 0);
		for (int unsigned i = 0; i < n_items; i++) begin
			pfx = ByteW'($urandom_range(0, 255));
			if (i == stop_item && pfx[1:0] == SizeNone)
				pfx[1:0] = 2'($urandom_range(1, 3));
			k = (i == stop_item) ? $urandom_range(0, data_bytes(pfx) - 1) : data_bytes(pfx);
			flag_end = (i == n_items - 1 || i == stop_item) && !(i == stop_item && abandon);
			drive_byte(pfx, i == 0, flag_end && k == 0);
			for (int unsigned j = 0; j < k; j++)
				drive_byte(ByteW'($urandom_range(0, 255)), 1'b0, flag_end && j == k - 1);
			if (i == stop_item)
				return;
		end
	endtask

	task automatic send_noise(input int unsigned n);
		repeat (n)
			drive_byte(ByteW'($urandom_range(0, 255)), $urandom_range(0, 5) == 0,
				$urandom_range(0, 5) == 0);
	endtask

	task automatic send_random_stream(input int unsigned n_bytes);
		int unsigned stop_at;
		int unsigned pick;
		stop_at = bytes_sent + n_bytes;
		while (bytes_sent < stop_at) begin
			pick = $urandom_range(0, 9);
			if (pick < 7)
				send_descriptor($urandom_range(1, 8), 1'b0);
			else if (pick < 9)
				send_descriptor($urandom_range(1, 8), 1'b1);
			else
				send_noise($urandom_range(1, 6));
		end
	endtask

	task automatic test_named_items();
		drive_byte(8'h00, 1'b1, 1'b0);                  // main tag 0: unnamed
		drive_byte(8'h05, 1'b0, 1'b0);                  // usage page
		drive_byte(8'hFF, 1'b0, 1'b0);
		drive_byte(8'hA1, 1'b0, 1'b0);                  // collection
		drive_byte(8'h01, 1'b0, 1'b0);
		drive_byte(EndCollPrefix, 1'b0, 1'b0);
		drive_byte(8'h27, 1'b0, 1'b0);                  // four data bytes
		repeat (4) drive_byte(8'hFF, 1'b0, 1'b0);
		drive_byte(8'hFE, 1'b0, 1'b0);                  // reserved type, reserved tag
		drive_byte(8'h00, 1'b0, 1'b0);
		drive_byte(8'h80, 1'b0, 1'b0);
		drive_byte(8'h88, 1'b0, 1'b0);                  // local tag 8: reserved
		drive_byte(8'hC4, 1'b0, 1'b0);                  // global tag 12: unnamed
		drive_byte(8'h0C, 1'b0, 1'b1);                  // reserved type tag 0: unnamed
	endtask

	task automatic test_truncation_and_restart();
		drive_byte(8'h26, 1'b1, 1'b1);                  // last on a prefix that wants data
		drive_byte(8'h27, 1'b1, 1'b0);
		drive_byte(8'h11, 1'b0, 1'b0);
		drive_byte(8'h22, 1'b0, 1'b1);                  // cut after two of four bytes
		drive_byte(8'h26, 1'b1, 1'b0);
		drive_byte(8'h55, 1'b0, 1'b0);
		drive_byte(8'h08, 1'b1, 1'b1);                  // restart drops the partial item
	endtask

	task automatic test_random_descriptors();
		send_random_stream(600);
	endtask

	task automatic test_output_backpressure();
		src_gaps     = 1'b0;
		hold_request = HoldCycles;
		send_random_stream(130);
		src_gaps = 1'b1;
	endtask

	task automatic test_no_idle();
		src_gaps = 1'b0;
		snk_gaps = 1'b0;
		send_random_stream(150);
	endtask

	// sink: random stall bursts plus the long hold-off requested by the back-pressure test
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request != 0) begin
				m_tready <= 1'b0;
				hold_request--;
			end else if (stall_left != 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (snk_gaps && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				stall_left = $urandom_range(0, 14);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		hidt_res_t got;
		hidt_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.item_type      = m_tdata[1:0];
			got.item_tag       = m_tdata[5:2];
			got.data_length    = m_tdata[8:6];
			got.item_value     = m_tdata[40:9];
			got.item_kind      = m_tdata[45:41];
			got.end_collection = m_tuser[0];
			got.truncated      = m_tuser[1];
			items_seen++;
			if (got.truncated)
				trunc_seen++;
			if (got.end_collection)
				endc_seen++;
			if (expected_items.size() == 0) begin
				n_errors++;
				if (n_errors <= MaxReports)
					$display("unexpected item: %s", item_text(got));
			end else begin
				want = expected_items.pop_front();
				if (got.item_type !== want.item_type || got.item_tag !== want.item_tag ||
					got.data_length !== want.data_length ||
					got.item_value !== want.item_value || got.item_kind !== want.item_kind ||
					got.end_collection !== want.end_collection ||
					got.truncated !== want.truncated) begin
					n_errors++;
					if (n_errors <= MaxReports)
						$display("item %0d mismatch: expected %s, got %s", items_seen,
							item_text(want), item_text(got));
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IdleLimit) begin
			$display("watchdog: no beat for %0d cycles", IdleLimit);
			$display("hid_descriptor_item_tokenizer_tb: done, errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		test_named_items();
		test_truncation_and_restart();
		test_random_descriptors();
		test_output_backpressure();
		test_no_idle();
		stop_driving();
		while (expected_items.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		$display("%0d descriptor bytes in, %0d items out (%0d truncated, %0d end collection)",
			bytes_sent, items_seen, trunc_seen, endc_seen);
		$display("random descriptors with cut-offs and restarts, long sink hold-off, %0d errors",
			n_errors);
		if (n_errors == 0)
			$display("hid_descriptor_item_tokenizer_tb: done, clean");
		else
			$display("hid_descriptor_item_tokenizer_tb: done, errors");
		$finish;
	end

endmodule
